[hdl/hbp_pkg.sv]
// ----------------------------------------------------------------------------
// hbp_pkg
// Types and constants shared by the bit packer: item and result words, the
// command word passed from the front end to the back end, and action codes.
// ----------------------------------------------------------------------------
package hbp_pkg;

    // Widest bit run one command can carry (covers every legal code length)
    localparam int SEG_W       = 64;
    localparam int NBITS_W     = 7;
    localparam int ACC_W       = SEG_W + 8;
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = 3;

    typedef enum logic [1:0] {
        ACT_SYMBOL = 2'd0,
        ACT_CODE   = 2'd1,
        ACT_FLUSH  = 2'd2
    } hbp_action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [8:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } hbp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } hbp_out_t;

    // Bits left-aligned: bits[SEG_W-1] goes out first
    typedef struct packed {
        logic               flush;
        logic [NBITS_W-1:0] nbits;
        logic [SEG_W-1:0]   bits;
    } hbp_cmd_t;

endpackage

[hdl/hbp_fifo.sv]
// ----------------------------------------------------------------------------
// hbp_fifo
// Small register queue with push/full and pop/empty; head shown while not empty.
// ----------------------------------------------------------------------------
module hbp_fifo #(
    parameter int  DEPTH = 4,
    parameter type T     = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/hbp_front.sv]
// ----------------------------------------------------------------------------
// hbp_front
// Classifies an input word and turns it into a left-aligned bit run for the
// back end. Words that add no bits and flush nothing are dropped here.
// ----------------------------------------------------------------------------
module hbp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_BITS  = 9
) (
    input  hbp_pkg::hbp_in_t  item,
    output hbp_pkg::hbp_cmd_t cmd,
    output logic              keep
);
    import hbp_pkg::*;

    logic [NBITS_W-1:0]  code_nbits;
    logic [SEG_W+31:0]   code_wide;

    // Saturate overlong codes, then shift so bit nbits-1 lands on top
    assign code_nbits = (item.code_length > 6'(MAX_CODE_LEN)) ? NBITS_W'(MAX_CODE_LEN)
                                                              : NBITS_W'(item.code_length);
    assign code_wide  = {{SEG_W{1'b0}}, item.code_bits} << (NBITS_W'(SEG_W) - code_nbits);

    always_comb
    begin
        cmd  = '0;
        keep = 1'b0;
        unique case (item.action)
            ACT_SYMBOL:
            begin
                // Symbol goes out least significant bit first
                for (int k = 0; k < 9; k++)
                begin
                    if (k < SYMBOL_BITS)
                    begin
                        cmd.bits[SEG_W-1-k] = item.symbol[k];
                    end
                end
                cmd.nbits = NBITS_W'(SYMBOL_BITS);
                keep      = 1'b1;
            end
            ACT_CODE:
            begin
                cmd.bits  = code_wide[SEG_W-1:0];
                cmd.nbits = code_nbits;
                keep      = (item.code_length != '0);
            end
            ACT_FLUSH:
            begin
                cmd.flush = 1'b1;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

[hdl/hbp_back.sv]
// ----------------------------------------------------------------------------
// hbp_back
// Merges each command's bits behind the partial byte, then hands the finished
// bytes on, one a cycle while the result queue has room, marking the final one.
// ----------------------------------------------------------------------------
module hbp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hbp_pkg::hbp_cmd_t head,
    input  logic              head_empty,
    output logic              head_pop,
    output hbp_pkg::hbp_out_t res,
    output logic              res_push,
    input  logic              res_full
);
    import hbp_pkg::*;

    logic [7:0]           partial_reg, partial_next;
    logic [2:0]           fill_reg, fill_next;
    logic [31:0]          bytes_reg, bytes_next;
    logic [RES_CNT_W-1:0] rem_reg, rem_next;

    logic [NBITS_W-1:0]   total;
    logic [3:0]           nbytes;
    logic [ACC_W-1:0]     acc;
    logic [8:0][7:0]      acc_b;
    logic [RES_CNT_W-1:0] load_cnt;
    logic                 emit;
    logic                 can_load;

    assign total  = NBITS_W'(fill_reg) + head.nbits;
    assign nbytes = total[NBITS_W-1:3];
    assign acc    = {partial_reg, {SEG_W{1'b0}}} | ({head.bits, 8'b0} >> fill_reg);
    assign acc_b  = acc;

    // Further bytes past the result limit are dropped
    assign load_cnt = (nbytes > 4'(MAX_RESULTS)) ? RES_CNT_W'(MAX_RESULTS)
                                                 : RES_CNT_W'(nbytes);

    assign emit     = (rem_reg != '0) && !res_full;
    assign can_load = (rem_reg == '0) || (emit && (rem_reg == RES_CNT_W'(1)));
    assign head_pop = can_load && !head_empty;

    assign res_push     = emit;
    assign res.out_byte = bytes_reg[31:24];
    assign res.last     = (rem_reg == RES_CNT_W'(1));

    always_comb
    begin
        partial_next = partial_reg;
        fill_next    = fill_reg;
        bytes_next   = bytes_reg;
        rem_next     = rem_reg;
        priority if (head_pop)
        begin
            if (head.flush)
            begin
                bytes_next   = {partial_reg, 24'b0};
                rem_next     = RES_CNT_W'(1);
                partial_next = '0;
                fill_next    = '0;
            end
            else
            begin
                bytes_next   = acc[ACC_W-1 -: 32];
                rem_next     = load_cnt;
                partial_next = acc_b[4'd8 - nbytes];
                fill_next    = total[2:0];
            end
        end
        else if (emit)
        begin
            bytes_next = {bytes_reg[23:0], 8'b0};
            rem_next   = rem_reg - 1'b1;
        end
        else
        begin
            // hold pending bytes
            bytes_next = bytes_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            fill_reg    <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
            rem_reg     <= rem_next;
        end
    end

    a_rem_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("byte count above result limit");

    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (rem_reg == '0) || (emit && rem_reg == RES_CNT_W'(1)))
        else $error("command taken while bytes still pending");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop && head.flush |=> (fill_reg == '0) && (partial_reg == '0)
                                   && (rem_reg == RES_CNT_W'(1)))
        else $error("flush did not clear the partial byte");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) && res_full |=> $stable(bytes_reg) && $stable(rem_reg))
        else $error("pending bytes moved while result queue full");

endmodule

[hdl/huffman_bit_packer.sv]
// ----------------------------------------------------------------------------
// huffman_bit_packer
// MSB-first bit packer: appends symbols and codes, emits finished bytes.
// ----------------------------------------------------------------------------
// Input words are taken one a cycle while the four-entry command queue has
// room; the front end turns each into a left-aligned bit run at once. The back
// end merges a run behind the partial byte as it takes the command and then
// delivers the finished bytes one a cycle, while there is room, into a
// four-entry result queue; it takes the next command as it sends the last
// byte of the one before. The byte rate of the back end is what sets sustained
// throughput. Flush always gives one byte, even when empty.
module huffman_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_BITS  = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hbp_pkg::hbp_in_t  item,
    output logic              full,
    input  logic              pop,
    output hbp_pkg::hbp_out_t result,
    output logic              empty
);
    import hbp_pkg::*;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    hbp_cmd_t cmd;
    hbp_cmd_t head;
    hbp_out_t res;
    logic     keep;
    logic     cmd_push;
    logic     head_empty;
    logic     head_pop;
    logic     res_push;
    logic     res_full;

    hbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_front (
        .item (item),
        .cmd  (cmd),
        .keep (keep)
    );

    // Drop words that change nothing; they are still accepted
    assign cmd_push = push && keep;

    hbp_fifo #(
        .DEPTH (CMD_DEPTH),
        .T     (hbp_cmd_t)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd),
        .full  (full),
        .pop   (head_pop),
        .rdata (head),
        .empty (head_empty)
    );

    hbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .res        (res),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    hbp_fifo #(
        .DEPTH (RES_DEPTH),
        .T     (hbp_out_t)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

[test/huffman_bit_packer_tb.sv]
// ----------------------------------------------------------------------------
// huffman_bit_packer_tb
// Self-checking bench for the MSB-first bit packer. Symbol, code and flush
// words go in through the push side, in bursts with random gaps. A bit-level
// packing model predicts every finished byte and its last flag. Each popped
// byte is compared with the oldest prediction. The receiver stalls on its own
// pattern, and at one point holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module huffman_bit_packer_tb;

    import hbp_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         CODE_LEN_MAX   = 32;
    localparam int         SYM_BITS       = 9;
    localparam int         HOLD_CYCLES    = 120;
    localparam int         DRAIN_CYCLES   = 24;
    localparam int         WATCHDOG_LIMIT = 1000;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     push  = 1'b0;
    hbp_in_t  din   = '0;
    logic     full;
    logic     pop   = 1'b0;
    hbp_out_t dout;
    logic     empty;

    // packing model state
    logic [7:0] model_acc  = '0;
    int         model_fill = 0;
    int         new_bytes  = 0;
    hbp_out_t   pending_bytes[$];

    int   mismatches  = 0;
    // toggled by the sequence; the receiver starts a hold-off on each change
    logic rx_hold_req = 1'b0;
    logic hold_ack    = 1'b0;
    int   hold_left   = 0;
    int   rx_mode     = 0;
    int   rx_cycle    = 0;

    huffman_bit_packer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (din),
        .full   (full),
        .pop    (pop),
        .result (dout),
        .empty  (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Packing model
    // ------------------------------------------------------------------
    function automatic void shift_in(input logic b);
        hbp_out_t word;
        model_acc[7 - model_fill] = b;
        model_fill++;
        if (model_fill == 8)
        begin
            word.out_byte = model_acc;
            word.last     = 1'b0;
            pending_bytes.push_back(word);
            new_bytes++;
            model_acc  = '0;
            model_fill = 0;
        end
    endfunction

    function automatic void pack_word(input hbp_in_t w);
        hbp_out_t word;
        int       len;
        new_bytes = 0;
        case (w.action)
            ACT_SYMBOL:
            begin
                for (int k = 0; k < SYM_BITS; k++)
                    shift_in(w.symbol[k]);
            end
            ACT_CODE:
            begin
                len = (w.code_length > CODE_LEN_MAX) ? CODE_LEN_MAX : int'(w.code_length);
                for (int k = len; k > 0; k--)
                    shift_in(w.code_bits[k - 1]);
            end
            ACT_FLUSH:
            begin
                word.out_byte = model_acc;
                word.last     = 1'b0;
                pending_bytes.push_back(word);
                new_bytes  = 1;
                model_acc  = '0;
                model_fill = 0;
            end
            default: ;
        endcase
        // tag the final byte of this word
        if (new_bytes > 0)
        begin
            word      = pending_bytes.pop_back();
            word.last = 1'b1;
            pending_bytes.push_back(word);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic hbp_in_t make_word(input logic [1:0] act, input logic [8:0] sym,
                                          input logic [31:0] code, input logic [5:0] len);
        hbp_in_t w;
        w.action      = act;
        w.symbol      = sym;
        w.code_bits   = code;
        w.code_length = len;
        return w;
    endfunction

    function automatic hbp_in_t random_word();
        int         pick;
        logic [1:0] act;
        logic [5:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            act = ACT_SYMBOL;
        else if (pick < 75)
            act = ACT_CODE;
        else if (pick < 92)
            act = ACT_FLUSH;
        else
            act = ACT_UNUSED;
        if ($urandom_range(0, 99) < 85)
            len = 6'($urandom_range(0, CODE_LEN_MAX));
        else
            len = 6'($urandom_range(CODE_LEN_MAX + 1, 63));
        return make_word(act, 9'($urandom), $urandom, len);
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input hbp_in_t w);
        push <= 1'b1;
        din  <= w;
        do
            @(posedge clk);
        while (full);
        pack_word(w);
    endtask

    task automatic idle_sender(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        // let words that give no byte clear the pipeline
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_stream(input int count);
        hbp_in_t w;
        int      sent;
        int      burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                w = random_word();
                send_word(w);
                if (w.action != ACT_UNUSED)
                    sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_edge_cases();
        send_word(make_word(ACT_FLUSH, 9'h000, 32'h0000_0000, 6'd0));   // empty flush
        send_word(make_word(ACT_SYMBOL, 9'h1FF, 32'h0000_0000, 6'd0));
        send_word(make_word(ACT_SYMBOL, 9'h000, 32'hFFFF_FFFF, 6'd63));
        send_word(make_word(ACT_SYMBOL, 9'h155, 32'h0000_0000, 6'd0));
        send_word(make_word(ACT_CODE, 9'h1FF, 32'hFFFF_FFFF, 6'd0));     // empty code
        send_word(make_word(ACT_CODE, 9'h000, 32'h0000_0001, 6'd1));
        send_word(make_word(ACT_CODE, 9'h000, 32'hFFFF_FFFF, 6'd32));
        send_word(make_word(ACT_CODE, 9'h000, 32'h8000_0001, 6'd32));
        send_word(make_word(ACT_CODE, 9'h000, 32'hDEAD_BEEF, 6'd33));    // saturates
        send_word(make_word(ACT_CODE, 9'h0AA, 32'h1234_5678, 6'd63));
        send_word(make_word(ACT_UNUSED, 9'h1FF, 32'hFFFF_FFFF, 6'd32));
        send_word(make_word(ACT_CODE, 9'h000, 32'h0000_007F, 6'd7));
        send_word(make_word(ACT_FLUSH, 9'h1FF, 32'hFFFF_FFFF, 6'd63));
        send_word(make_word(ACT_FLUSH, 9'h000, 32'h0000_0000, 6'd0));
        send_word(make_word(ACT_CODE, 9'h000, 32'h0000_00A5, 6'd8));     // exact byte
        send_word(make_word(ACT_FLUSH, 9'h000, 32'h0000_0000, 6'd0));
        send_word(make_word(ACT_CODE, 9'h000, 32'h5555_5555, 6'd31));
        send_word(make_word(ACT_SYMBOL, 9'h0AA, 32'h0000_0000, 6'd0));
        send_word(make_word(ACT_CODE, 9'h000, 32'h0000_0003, 6'd2));     // fills nothing
        send_word(make_word(ACT_FLUSH, 9'h000, 32'h0000_0000, 6'd0));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        send_random_stream(count);
    endtask

    // Hold the receiver off and offer thirty long codes, enough to back the block up.
    task automatic test_output_backpressure();
        rx_hold_req <= ~rx_hold_req;
        for (int i = 0; i < 30; i++)
            send_word(make_word(ACT_CODE, 9'($urandom), $urandom, 6'd32));
        wait_drained();
    endtask

    task automatic test_pause_and_resume(input int count);
        send_random_stream(count);
        wait_drained();
        send_random_stream(count);
    endtask

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            hold_left <= 0;
            rx_mode   <= 0;
            rx_cycle  <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 48 == 47)
                rx_mode <= int'($urandom_range(0, 3));
            if (rx_hold_req != hold_ack)
            begin
                hold_ack  <= rx_hold_req;
                hold_left <= HOLD_CYCLES;
                pop       <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= (rx_cycle % 7 >= 2);
                    default: pop <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        hbp_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch("unexpected word, out_byte", dout.out_byte, 0);
            else
            begin
                want = pending_bytes.pop_front();
                if (dout.out_byte !== want.out_byte)
                    report_mismatch("out_byte", dout.out_byte, want.out_byte);
                if (dout.last !== want.last)
                    report_mismatch("last", dout.last, want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up after a long spell with no word moving either way
    // ------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_random_traffic(180);
        test_output_backpressure();
        test_pause_and_resume(40);
        wait_drained();

        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
